// ----- sv/scs_pkg.sv -----
// shared types, constants and helpers for the two-wire sound command sender
package scs_pkg;

    localparam int unsigned WORD_BITS_DEF     = 16;
    localparam int unsigned MAX_TRACK_DEF     = 512;
    localparam int unsigned VOLUME_LEVELS_DEF = 8;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CMD_EXT = 32;

    localparam logic [CFG_W-1:0] STOP_CODE_RST   = 16'd65535;
    localparam logic [CFG_W-1:0] VOLUME_BASE_RST = 16'd65520;
    localparam logic [CFG_W-1:0] START_RST       = 16'd2000;
    localparam logic [CFG_W-1:0] HALF_LOW_RST    = 16'd50;
    localparam logic [CFG_W-1:0] HIGH_RST        = 16'd100;
    localparam logic [CFG_W-1:0] GAP_RST         = 16'd2000;
    localparam logic [CFG_W-1:0] BUSY_RST        = 16'd20000;

    typedef enum logic [1:0] {
        FN_TICK   = 2'd0,
        FN_PLAY   = 2'd1,
        FN_STOP   = 2'd2,
        FN_VOLUME = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_INVALID = 2'd2,
        ST_BUSY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_STOP_CODE   = 3'd0,
        CFG_VOLUME_BASE = 3'd1,
        CFG_START       = 3'd2,
        CFG_HALF_LOW    = 3'd3,
        CFG_HIGH        = 3'd4,
        CFG_GAP         = 3'd5,
        CFG_BUSY        = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         func;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic       clk_line;
        logic       data_line;
        logic       busy_res;
        logic [1:0] status;
    } t_res;

    typedef struct packed {
        logic [TICK_W-1:0] start_ticks;
        logic [TICK_W-1:0] half_low_ticks;
        logic [TICK_W-1:0] high_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [TICK_W-1:0] busy_ticks;
    } t_timing;

    typedef struct packed {
        logic    go;
        t_status status;
    } t_req_ctl;

    typedef struct packed {
        logic clk_line;
        logic data_line;
        logic busy;
    } t_lines;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

// ----- sv/scs_cmd.sv -----
// request check and command word forming
module scs_cmd #(
    parameter int unsigned WORD_BITS     = scs_pkg::WORD_BITS_DEF,
    parameter int unsigned MAX_TRACK     = scs_pkg::MAX_TRACK_DEF,
    parameter int unsigned VOLUME_LEVELS = scs_pkg::VOLUME_LEVELS_DEF
) (
    input  scs_pkg::t_req                    i_req,
    input  logic                             i_idle,
    input  logic [scs_pkg::CFG_W-1:0]        i_stop_code,
    input  logic [scs_pkg::CFG_W-1:0]        i_volume_base,
    output scs_pkg::t_req_ctl                o_ctl,
    output logic [WORD_BITS-1:0]             o_cmd
);
    import scs_pkg::*;

    logic               track_ok;
    logic               vol_ok;
    logic [CMD_EXT-1:0] wide_cmd;

    assign track_ok = (i_req.value != '0)
                   && (CMD_EXT'(i_req.value) <= CMD_EXT'(MAX_TRACK));
    assign vol_ok   = CMD_EXT'(i_req.value) < CMD_EXT'(VOLUME_LEVELS);

    always_comb begin
        o_ctl.go     = 1'b0;
        o_ctl.status = ST_NONE;
        wide_cmd     = '0;
        case (i_req.func)
            FN_TICK: begin
                o_ctl.status = ST_NONE;
            end
            FN_PLAY: begin
                wide_cmd = CMD_EXT'(i_req.value);
                o_ctl.go = track_ok;
                o_ctl.status = track_ok ? ST_ACCEPT : ST_INVALID;
            end
            FN_STOP: begin
                wide_cmd = CMD_EXT'(i_stop_code);
                o_ctl.go = 1'b1;
                o_ctl.status = ST_ACCEPT;
            end
            FN_VOLUME: begin
                wide_cmd = CMD_EXT'(i_volume_base) + CMD_EXT'(i_req.value);
                o_ctl.go = vol_ok;
                o_ctl.status = vol_ok ? ST_ACCEPT : ST_INVALID;
            end
            default: begin
                o_ctl.status = ST_NONE;
            end
        endcase
        if (i_req.func != FN_TICK && !i_idle) begin
            o_ctl.go     = 1'b0;
            o_ctl.status = ST_BUSY;
        end
    end

    assign o_cmd = wide_cmd[WORD_BITS-1:0];

endmodule

// ----- sv/scs_seq.sv -----
// bit sequencer: phase, tick counter, shift word and line levels
module scs_seq #(
    parameter int unsigned WORD_BITS = scs_pkg::WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_go,
    input  logic [WORD_BITS-1:0]  i_cmd,
    input  scs_pkg::t_timing      i_tim,
    output logic                  o_idle,
    output scs_pkg::t_lines       o_lines
);
    import scs_pkg::*;

    localparam int unsigned BITS_W = $clog2(WORD_BITS + 1);

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_START = 7'b0000010,
        PH_LOW   = 7'b0000100,
        PH_HOLD  = 7'b0001000,
        PH_HIGH  = 7'b0010000,
        PH_GAP   = 7'b0100000,
        PH_BUSY  = 7'b1000000
    } t_phase;

    t_phase               r_phase, n_phase, c_phase;
    logic [TICK_W-1:0]    r_tick, n_tick, c_tick;
    logic [WORD_BITS-1:0] r_shift, n_shift, c_shift;
    logic [BITS_W-1:0]    r_bits, n_bits, c_bits, bits_dec;
    logic                 r_clk, n_clk, c_clk;
    logic                 r_data, n_data, c_data;

    assign o_idle = (r_phase == PH_IDLE);

    always_comb begin
        c_phase = r_phase;
        c_tick  = r_tick;
        c_shift = r_shift;
        c_bits  = r_bits;
        c_clk   = r_clk;
        c_data  = r_data;
        if (i_go) begin
            c_phase = PH_START;
            c_tick  = at_least_one(i_tim.start_ticks);
            c_shift = i_cmd;
            c_bits  = BITS_W'(WORD_BITS);
            c_clk   = 1'b0;
        end

        o_lines.clk_line  = c_clk;
        o_lines.data_line = c_data;
        o_lines.busy      = (c_phase != PH_IDLE);

        bits_dec = (c_bits != '0) ? c_bits - BITS_W'(1) : c_bits;

        n_phase = c_phase;
        n_tick  = c_tick;
        n_shift = c_shift;
        n_bits  = c_bits;
        n_clk   = c_clk;
        n_data  = c_data;
        if (c_phase != PH_IDLE) begin
            n_tick = (c_tick != '0) ? c_tick - TICK_W'(1) : c_tick;
            if (n_tick == '0) begin
                case (c_phase)
                    PH_START, PH_GAP: begin
                        n_clk   = 1'b0;
                        n_phase = PH_LOW;
                        n_tick  = at_least_one(i_tim.half_low_ticks);
                    end
                    PH_LOW: begin
                        n_data  = c_shift[WORD_BITS-1];
                        n_phase = PH_HOLD;
                        n_tick  = at_least_one(i_tim.half_low_ticks);
                    end
                    PH_HOLD: begin
                        n_clk   = 1'b1;
                        n_phase = PH_HIGH;
                        n_tick  = at_least_one(i_tim.high_ticks);
                    end
                    PH_HIGH: begin
                        n_shift = {c_shift[WORD_BITS-2:0], 1'b0};
                        n_bits  = bits_dec;
                        if (bits_dec != '0) begin
                            if (i_tim.gap_ticks != '0) begin
                                n_phase = PH_GAP;
                                n_tick  = i_tim.gap_ticks;
                            end else begin
                                n_clk   = 1'b0;
                                n_phase = PH_LOW;
                                n_tick  = at_least_one(i_tim.half_low_ticks);
                            end
                        end else if (i_tim.busy_ticks != '0) begin
                            n_phase = PH_BUSY;
                            n_tick  = i_tim.busy_ticks;
                        end else begin
                            n_phase = PH_IDLE;
                            n_tick  = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_shift <= '0;
            r_bits  <= '0;
            r_clk   <= 1'b1;
            r_data  <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_clk   <= n_clk;
            r_data  <= n_data;
        end
    end

endmodule

// ----- sv/two_wire_sound_command_sender.sv -----
// top level: two-wire sound module command sender
// path: an accepted item is held in the input register; its result is
// written to the result register when the sequencer steps
// throughput: one item per cycle while no unread result blocks the step
// reset: lines high, sequencer idle, registers at their defaults, no item held
module two_wire_sound_command_sender #(
    parameter int unsigned WORD_BITS     = scs_pkg::WORD_BITS_DEF,
    parameter int unsigned MAX_TRACK     = scs_pkg::MAX_TRACK_DEF,
    parameter int unsigned VOLUME_LEVELS = scs_pkg::VOLUME_LEVELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  scs_pkg::t_req             i_req,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output scs_pkg::t_res             o_res,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_idx,
    input  logic [scs_pkg::CFG_W-1:0] i_cfg_data
);
    import scs_pkg::*;

    logic [CFG_W-1:0]     r_stop_code, r_volume_base;
    t_timing              r_tim;
    logic                 r_in_valid;
    t_req                 r_in;
    logic                 r_out_valid;
    t_res                 r_out;
    logic                 step;
    logic                 idle;
    t_req_ctl             ctl;
    logic [WORD_BITS-1:0] cmd;
    t_lines               lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_code          <= STOP_CODE_RST;
            r_volume_base        <= VOLUME_BASE_RST;
            r_tim.start_ticks    <= START_RST;
            r_tim.half_low_ticks <= HALF_LOW_RST;
            r_tim.high_ticks     <= HIGH_RST;
            r_tim.gap_ticks      <= GAP_RST;
            r_tim.busy_ticks     <= BUSY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STOP_CODE:   r_stop_code          <= i_cfg_data;
                CFG_VOLUME_BASE: r_volume_base        <= i_cfg_data;
                CFG_START:       r_tim.start_ticks    <= i_cfg_data;
                CFG_HALF_LOW:    r_tim.half_low_ticks <= i_cfg_data;
                CFG_HIGH:        r_tim.high_ticks     <= i_cfg_data;
                CFG_GAP:         r_tim.gap_ticks      <= i_cfg_data;
                CFG_BUSY:        r_tim.busy_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign step        = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_req_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_in_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
    end

    scs_cmd #(
        .WORD_BITS     (WORD_BITS),
        .MAX_TRACK     (MAX_TRACK),
        .VOLUME_LEVELS (VOLUME_LEVELS)
    ) u_cmd (
        .i_req         (r_in),
        .i_idle        (idle),
        .i_stop_code   (r_stop_code),
        .i_volume_base (r_volume_base),
        .o_ctl         (ctl),
        .o_cmd         (cmd)
    );

    scs_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_go    (ctl.go),
        .i_cmd   (cmd),
        .i_tim   (r_tim),
        .o_idle  (idle),
        .o_lines (lines)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.clk_line  <= lines.clk_line;
            r_out.data_line <= lines.data_line;
            r_out.busy_res  <= lines.busy;
            r_out.status    <= ctl.status;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_ACCEPT) |-> o_res.busy_res)
        else $error("accepted item without busy");

    a_busy_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_BUSY) |-> o_res.busy_res)
        else $error("busy status while idle");

    a_invalid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_INVALID) |-> !o_res.busy_res)
        else $error("rejected item left sequencer busy");

    a_step_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed item lost from result register");
`endif

endmodule
